// ----- sv/sdf_pkg.sv -----
package sdf_pkg;

    localparam int MAX_FIELD = 63;
    localparam int NUM_DIGITS = 20;
    localparam int CNT_W = 7;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [2:0] SZ_INT32 = 3'd0;
    localparam logic [2:0] SZ_CHAR8 = 3'd1;
    localparam logic [2:0] SZ_SHORT16 = 3'd2;
    localparam logic [2:0] SZ_LLONG64 = 3'd3;
    localparam logic [2:0] SZ_LONG64 = 3'd4;

    typedef struct packed {
        logic signed [63:0] value;
        logic [2:0]         int_size;
        logic [5:0]         field_width;
        logic [5:0]         digit_precision;
        logic               has_precision;
        logic               zero_fill;
        logic               left_align;
        logic               force_plus;
        logic               space_sign;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic [5:0] char_index;
        logic       last_char;
    } t_out_word;

    // classified job handed from front to back
    typedef struct packed {
        logic [63:0] mag;
        logic [7:0]  sign_char;
        logic        has_sign;
        logic        suppress;
        logic [5:0]  field_width;
        logic [5:0]  digit_precision;
        logic        has_precision;
        logic        zfill;
        logic        left_align;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PLAN,
        ST_EMIT
    } t_back_state;

endpackage

// ----- sv/sdf_front.sv -----
module sdf_front
    import sdf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_word,
    output logic     o_valid,
    input  logic     i_ready,
    output t_job     o_job
);

    logic [63:0] nv;
    logic        neg;
    t_job        job;
    t_job        r_q [2];
    logic [1:0]  r_cnt;
    logic        r_wp, r_rp;
    logic        push, pop;

    // narrow and classify
    always_comb begin
        unique case (i_word.int_size)
            SZ_CHAR8:   nv = {{56{i_word.value[7]}}, i_word.value[7:0]};
            SZ_SHORT16: nv = {{48{i_word.value[15]}}, i_word.value[15:0]};
            SZ_LLONG64, SZ_LONG64: nv = i_word.value;
            default:    nv = {{32{i_word.value[31]}}, i_word.value[31:0]};
        endcase
        neg = nv[63];
        job.mag = neg ? (~nv + 64'd1) : nv;
        job.has_sign = neg | i_word.force_plus | i_word.space_sign;
        job.sign_char = neg ? CH_MINUS : (i_word.force_plus ? CH_PLUS : CH_SPACE);
        job.suppress = (nv == 64'd0) && i_word.has_precision
                       && (i_word.digit_precision == 6'd0);
        job.field_width = i_word.field_width;
        job.digit_precision = i_word.digit_precision;
        job.has_precision = i_word.has_precision;
        job.zfill = i_word.zero_fill & ~i_word.has_precision & ~i_word.left_align;
        job.left_align = i_word.left_align;
    end

    // two-entry queue
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push = i_valid & o_ready;
    assign pop = o_valid & i_ready;
    assign o_job = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= job;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- sv/sdf_back.sv -----
module sdf_back
    import sdf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [63:0] r_bin;
    logic [79:0] r_bcd;
    logic [6:0]  r_step;
    logic [4:0]  r_nd;
    logic [6:0]  r_pad, r_zeros, r_total, r_pos;
    logic        r_ov;
    logic [7:0]  r_ch;
    logic [5:0]  r_idx;
    logic        r_last;

    logic [79:0] adj;
    logic [4:0]  nd;
    logic [6:0]  core, zc, pad, tot;
    logic [7:0]  ch;
    logic [6:0]  p, dpos;
    logic [4:0]  di;
    logic        take_out, emit;

    // add-3 correction before each shift
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            adj[k*4 +: 4] = (r_bcd[k*4 +: 4] > 4'd4) ? r_bcd[k*4 +: 4] + 4'd3
                                                      : r_bcd[k*4 +: 4];
        end
    end

    // digit count: highest nonzero digit
    always_comb begin
        nd = 5'd1;
        for (int k = 1; k < NUM_DIGITS; k++) begin
            if (r_bcd[k*4 +: 4] != 4'd0) nd = 5'(k + 1);
        end
        if (r_job.suppress) nd = 5'd0;
        zc = (r_job.has_precision && ({1'b0, r_job.digit_precision} > {2'b0, nd}))
             ? ({1'b0, r_job.digit_precision} - {2'b0, nd}) : 7'd0;
        core = {6'b0, r_job.has_sign} + zc + {2'b0, nd};
        pad = ({1'b0, r_job.field_width} > core) ? {1'b0, r_job.field_width} - core : 7'd0;
        tot = core + pad;
    end

    // character selection for position r_pos
    always_comb begin
        p = r_pos;
        ch = CH_SPACE;
        dpos = 7'd0;
        di = 5'd0;
        if (!r_job.left_align && !r_job.zfill) begin
            if (p < r_pad) ch = CH_SPACE;
            else p = p - r_pad;
        end
        if (r_job.left_align || r_job.zfill || r_pos >= r_pad) begin
            if (r_job.has_sign && p == 7'd0) ch = r_job.sign_char;
            else begin
                if (r_job.has_sign) p = p - 7'd1;
                if (r_job.zfill && p < r_pad) ch = CH_ZERO;
                else begin
                    if (r_job.zfill) p = p - r_pad;
                    if (p < r_zeros) ch = CH_ZERO;
                    else begin
                        dpos = p - r_zeros;
                        if (dpos < {2'b0, r_nd}) begin
                            di = 5'(r_nd - 5'd1 - dpos[4:0]);
                            ch = CH_ZERO | {4'b0, r_bcd[di*4 +: 4]};
                        end else ch = CH_SPACE;
                    end
                end
            end
        end
    end

    assign take_out = ~r_ov | i_ready;
    assign emit = (r_state == ST_EMIT) && take_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_CONV;
            ST_CONV: if (r_step == 7'd63) n_state = ST_PLAN;
            ST_PLAN: n_state = (tot == 7'd0) ? ST_IDLE : ST_EMIT;
            ST_EMIT: if (emit && (r_pos + 7'd1 == r_total)) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = (r_state == ST_IDLE);
        o_valid = r_ov;
        o_word.out_char = r_ch;
        o_word.char_index = r_idx;
        o_word.last_char = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_job <= i_job;
            r_bin <= i_job.mag;
            r_bcd <= '0;
            r_step <= 7'd0;
        end
        if (r_state == ST_CONV) begin
            r_bcd <= {adj[78:0], r_bin[63]};
            r_bin <= {r_bin[62:0], 1'b0};
            r_step <= r_step + 7'd1;
        end
        if (r_state == ST_PLAN) begin
            r_nd <= nd;
            r_zeros <= zc;
            r_pad <= pad;
            r_total <= (tot > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : tot;
            r_pos <= 7'd0;
        end
        if (emit) begin
            r_ch <= ch;
            r_idx <= r_pos[5:0];
            r_last <= (r_pos + 7'd1 == r_total);
            r_pos <= r_pos + 7'd1;
        end
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

endmodule

// ----- sv/signed_decimal_field_formatter_top.sv -----
// An accepted word passes through the queue, the load, a 64-step double-dabble
// conversion and planning, then leaves one character per cycle unless i_ready stalls.
// A two-entry queue lets the next word be accepted while one converts.
// Reset: synchronous active-low i_rst_n clears queue and sequencer state.
module signed_decimal_field_formatter_top
    import sdf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    t_job job;
    logic jv, jr;

    sdf_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_word(i_data),
        .o_valid(jv), .i_ready(jr), .o_job(job)
    );

    sdf_back u_back (
        .i_clk, .i_rst_n, .i_valid(jv), .o_ready(jr), .i_job(job),
        .o_valid, .i_ready, .o_word(o_data)
    );

endmodule

// ----- sv/sdf_checker.sv -----
module sdf_checker
    import sdf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("out hold");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_data.last_char ##1 o_valid |->
        o_data.char_index == $past(o_data.char_index) + 6'd1) else $error("index step");

    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_data.last_char ##1 o_valid |->
        o_data.char_index == 6'd0) else $error("first index");

endmodule

bind signed_decimal_field_formatter_top sdf_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_data
);

// ----- bench/signed_decimal_field_formatter_top_test.sv -----
`timescale 1ns / 100ps

module signed_decimal_field_formatter_top_test;
    import sdf_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;

    t_out_word char_q[$];
    logic [7:0] pred_txt[$];
    int        n_err;
    bit        stim_done;

    signed_decimal_field_formatter_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_word),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_word)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial begin
        #400ms;
        $display("signed_decimal_field_formatter_top: mismatch");
        $finish;
    end

    // narrow the argument by size code, sign-extended back to 64 bits
    function automatic logic signed [63:0] narrow_value(logic [63:0] raw, logic [2:0] sz);
        case (sz)
            SZ_CHAR8:              return {{56{raw[7]}}, raw[7:0]};
            SZ_SHORT16:            return {{48{raw[15]}}, raw[15:0]};
            SZ_LLONG64, SZ_LONG64: return raw;
            default:               return {{32{raw[31]}}, raw[31:0]};
        endcase
    endfunction

    // build the field characters of one word and queue them
    task automatic format_field(t_in_word w);
        logic signed [63:0] sv;
        logic [63:0]        mag;
        logic [7:0]         digs[$];
        logic [7:0]         field[$];
        logic [7:0]         sign;
        bit                 has_sign;
        bit                 zfill;
        int                 zeros;
        int                 pad;
        int                 core;
        int                 lim;
        t_out_word          c;
        sv = narrow_value(w.value, w.int_size);
        mag = sv[63] ? (~sv + 64'd1) : sv;
        has_sign = 1'b1;
        if (sv[63]) sign = CH_MINUS;
        else if (w.force_plus) sign = CH_PLUS;
        else if (w.space_sign) sign = CH_SPACE;
        else has_sign = 1'b0;
        if (mag == 0) begin
            if (!(w.has_precision && w.digit_precision == 0)) digs.push_front(CH_ZERO);
        end else begin
            while (mag != 0) begin
                digs.push_front(CH_ZERO + 8'(mag % 10));
                mag = mag / 10;
            end
        end
        zeros = (w.has_precision && w.digit_precision > digs.size())
            ? w.digit_precision - digs.size() : 0;
        core = int'(has_sign) + zeros + digs.size();
        pad = (w.field_width > core) ? w.field_width - core : 0;
        zfill = w.zero_fill && !w.has_precision && !w.left_align;
        if (!w.left_align && !zfill) repeat (pad) field.push_back(CH_SPACE);
        if (has_sign) field.push_back(sign);
        if (zfill) repeat (pad) field.push_back(CH_ZERO);
        repeat (zeros) field.push_back(CH_ZERO);
        foreach (digs[i]) field.push_back(digs[i]);
        if (w.left_align) repeat (pad) field.push_back(CH_SPACE);
        lim = (field.size() > MAX_FIELD) ? MAX_FIELD : field.size();
        pred_txt.delete();
        for (int i = 0; i < lim; i++) begin
            c.out_char = field[i];
            c.char_index = 6'(i);
            c.last_char = (i + 1 == lim);
            char_q.push_back(c);
            pred_txt.push_back(field[i]);
        end
    endtask

    // directed rows: fields plus, where obvious, the full expected text
    typedef struct {
        t_in_word w;
        string    txt;
    } t_row;

    function automatic t_in_word mk(logic [63:0] v, logic [2:0] sz, int fw, int pr,
                                    bit hp, bit zf, bit la, bit fp, bit sp);
        t_in_word w;
        w.value = v; w.int_size = sz; w.field_width = 6'(fw);
        w.digit_precision = 6'(pr); w.has_precision = hp; w.zero_fill = zf;
        w.left_align = la; w.force_plus = fp; w.space_sign = sp;
        return w;
    endfunction

    t_row rows[$];

    function automatic t_in_word rand_word();
        t_in_word    w;
        logic [127:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom};
        w = rnd[$bits(t_in_word)-1:0];
        w.int_size = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0: w.value = 64'($signed($urandom_range(0, 200)) - 100);
            1: w.value = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: ;
        endcase
        if ($urandom_range(0, 3) != 0) w.field_width = 6'($urandom_range(0, 24));
        if ($urandom_range(0, 3) != 0) w.digit_precision = 6'($urandom_range(0, 24));
        return w;
    endfunction

    // send one word, with a random gap first; valid stays up when no gap follows
    task automatic send_word(t_in_word w);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        format_field(w);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // stimulus
    initial begin
        t_row r;
        in_valid = 1'b0;
        in_word = '0;
        rst_n = 1'b0;
        stim_done = 1'b0;
        n_err = 0;
        r.txt = "0";  r.w = mk(0, SZ_INT32, 0, 0, 0, 0, 0, 0, 0); rows.push_back(r);
        r.txt = "";   r.w = mk(0, SZ_INT32, 0, 0, 1, 0, 0, 0, 0); rows.push_back(r);
        r.txt = "+";  r.w = mk(0, SZ_INT32, 0, 0, 1, 0, 0, 1, 0); rows.push_back(r);
        r.txt = "-128"; r.w = mk(64'h80, SZ_CHAR8, 0, 0, 0, 0, 0, 0, 0); rows.push_back(r);
        r.txt = "-32768"; r.w = mk(64'h8000, SZ_SHORT16, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.txt = "-2147483648"; r.w = mk(64'h8000_0000, 3'd7, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.txt = "-9223372036854775808";
        r.w = mk(64'h8000_0000_0000_0000, SZ_LLONG64, 0, 0, 0, 0, 0, 0, 0); rows.push_back(r);
        r.txt = "+9223372036854775807";
        r.w = mk(64'h7FFF_FFFF_FFFF_FFFF, SZ_LONG64, 0, 0, 0, 0, 0, 1, 0); rows.push_back(r);
        r.txt = " 42"; r.w = mk(42, SZ_INT32, 0, 0, 0, 0, 0, 0, 1); rows.push_back(r);
        r.txt = "   -7"; r.w = mk(-7, SZ_INT32, 5, 0, 0, 0, 0, 0, 0); rows.push_back(r);
        r.txt = "-0007"; r.w = mk(-7, SZ_INT32, 5, 0, 0, 1, 0, 0, 0); rows.push_back(r);
        r.txt = "-7   "; r.w = mk(-7, SZ_INT32, 5, 0, 0, 1, 1, 0, 0); rows.push_back(r);
        r.txt = "  007"; r.w = mk(7, SZ_INT32, 5, 3, 1, 1, 0, 0, 0); rows.push_back(r);
        r.txt = "";  r.w = mk(-1, SZ_CHAR8, 63, 0, 0, 1, 0, 1, 1); rows.push_back(r);
        r.w = mk(-1, SZ_LLONG64, 63, 62, 1, 0, 1, 1, 1); rows.push_back(r);
        r.w = mk(5, SZ_INT32, 0, 63, 1, 0, 0, 1, 0); rows.push_back(r);  // cut to 63
        r.w = mk(5, SZ_INT32, 63, 0, 0, 0, 0, 0, 0); rows.push_back(r);
        r.w = mk(64'h1234_5678_9ABC_DEF0, 3'd5, 20, 15, 1, 0, 0, 0, 1); rows.push_back(r);
        r.w = mk(64'hFFFF_FFFF_FFFF_FFFF, 3'd6, 10, 0, 0, 1, 0, 1, 0); rows.push_back(r);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[k]) begin
            send_word(rows[k].w);
            // typed-in text must agree with the predictor
            if (rows[k].txt != "" || k == 1) begin
                if (pred_txt.size() != rows[k].txt.len()) begin
                    $error("row %0d length: expected %0d actual %0d", k,
                           rows[k].txt.len(), pred_txt.size());
                    n_err++;
                end else begin
                    for (int i = 0; i < rows[k].txt.len(); i++)
                        if (pred_txt[i] != rows[k].txt[i]) begin
                            $error("row %0d out_char: expected %h actual %h", k,
                                   rows[k].txt[i], pred_txt[i]);
                            n_err++;
                        end
                end
            end
        end
        // hold off until the block has drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (char_q.size() != 0) @(posedge clk);
        for (int k = 0; k < 500; k++) begin
            send_word(rand_word());
            if (k == 250) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (char_q.size() != 0) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receive side: random stall per word, then check
    int stall;
    initial begin
        out_ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (char_q.size() == 0) begin
                    $error("unexpected word: out_char %h", out_word.out_char);
                    n_err++;
                end else begin
                    t_out_word e;
                    e = char_q.pop_front();
                    if (e.out_char != out_word.out_char) begin
                        $error("out_char: expected %h actual %h", e.out_char, out_word.out_char);
                        n_err++;
                    end
                    if (e.char_index != out_word.char_index) begin
                        $error("char_index: expected %0d actual %0d", e.char_index,
                               out_word.char_index);
                        n_err++;
                    end
                    if (e.last_char != out_word.last_char) begin
                        $error("last_char: expected %b actual %b", e.last_char,
                               out_word.last_char);
                        n_err++;
                    end
                end
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                if ($urandom_range(0, 7) == 0) stall = 0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        while (char_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (n_err == 0 && char_q.size() == 0) begin
            $display("signed_decimal_field_formatter_top: match");
        end else begin
            $display("signed_decimal_field_formatter_top: mismatch");
        end
        $finish;
    end

endmodule
